### rtl/core/frp_pkg.sv
// ============================================================================
// Framed request parser package
// Shared types and fixed codes for the framed request parser core.
// ============================================================================
package frp_pkg;

    // Framing bytes.
    localparam logic [7:0] FRAME_HEADER = 8'hBB;
    localparam logic [7:0] VERSION_ID   = 8'h0A;

    // Configuration register indexes.
    localparam logic [1:0] REG_VERSION_LENGTH  = 2'd0;
    localparam logic [1:0] REG_VERSION_TEXT_LO = 2'd1;
    localparam logic [1:0] REG_VERSION_TEXT_HI = 2'd2;

    // Configuration reset values ("v1.0.0", six characters).
    localparam logic [3:0]  VERSION_LENGTH_RST  = 4'd6;
    localparam logic [63:0] VERSION_TEXT_LO_RST = 64'h0000_302E_302E_3176;
    localparam logic [7:0]  VERSION_TEXT_HI_RST = 8'h00;

    // Number of version characters held in the text registers.
    localparam int unsigned TEXT_CHARS = 9;

    // Parser phases.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ID      = 2'd1,
        PH_SIZE    = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

endpackage

### rtl/core/framed_request_parser_with_version_reply_core.sv
// ============================================================================
// Framed request parser with version reply
// Parses version request frames from a byte stream and answers each one
// with a fixed-length version reply frame.
// ============================================================================
// Usage:
// Received bytes enter on the s_ channel (s_valid, s_ready, s_rx_byte), one
// item per cycle. A frame is the header 0xBB, the ID 0x0A, a SIZE byte in
// 1..MAX_PAYLOAD and then SIZE payload bytes, which are counted and dropped.
// Anything else sends the parser back to waiting for a header.
// When the last payload byte is accepted the block sends a reply of
// REPLY_TEXT_BYTES+3 items on the m_ channel (m_valid, m_ready, m_tx_byte,
// m_tx_last): 0xBB, 0x0A, REPLY_TEXT_BYTES, the version characters, then
// zero padding. m_tx_last marks the final item. If version_length is not
// below REPLY_TEXT_BYTES the frame is consumed and no reply is sent.
// Throughput is one input item per cycle; the input is held off (s_ready
// low) while the reply generator is producing reply items. The first reply
// item is loaded into the output register once the reply generator has
// started, and the rest follow one per cycle while the receiver takes every
// item. When the receiver stalls, the output register holds its item and
// the reply generator waits; input items are still taken once the reply is
// fully generated. Reset (aresetn low, synchronous) returns the parser to
// waiting for a header, empties the output and restores the configuration
// defaults. The user must write the configuration port only while no frame
// is in progress; the block itself does not enforce this.
// ============================================================================
module framed_request_parser_with_version_reply_core #(
    parameter int unsigned MAX_PAYLOAD      = 64,
    parameter int unsigned REPLY_TEXT_BYTES = 10
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,

    // Received byte channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    // Reply byte channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_last
);

    import frp_pkg::*;

    // With the default REPLY_TEXT_BYTES the reply length is 13 items, so its index fits in four bits.
    localparam int unsigned REPLY_TOTAL = REPLY_TEXT_BYTES + 3;
    localparam int unsigned IDX_W       = $clog2(REPLY_TOTAL);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLY_TOTAL - 1);
    localparam logic [7:0] MAX_SIZE   = 8'(MAX_PAYLOAD);
    localparam logic [3:0] TEXT_LIMIT = 4'(REPLY_TEXT_BYTES);
    localparam logic [7:0] TEXT_COUNT = 8'(REPLY_TEXT_BYTES);

    // Configuration registers.
    logic [3:0]  version_length_reg;
    logic [63:0] version_text_lo_reg;
    logic [7:0]  version_text_hi_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [6:0]  size_reg, size_next;
    logic [6:0]  count_reg, count_next;
    logic        frame_done;

    // Reply generator and output register.
    logic             reply_active_reg, reply_active_next;
    logic [IDX_W-1:0] reply_idx_reg, reply_idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_tx_byte_reg, m_tx_byte_next;
    logic             m_tx_last_reg, m_tx_last_next;

    logic       s_accept;
    logic       out_load;
    logic [3:0] idx_wide;
    logic [3:0] text_pos;
    logic [7:0] text_char;
    logic [7:0] reply_byte;

    assign s_ready  = !reply_active_reg;
    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_length_reg  <= VERSION_LENGTH_RST;
            version_text_lo_reg <= VERSION_TEXT_LO_RST;
            version_text_hi_reg <= VERSION_TEXT_HI_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_VERSION_LENGTH:  version_length_reg  <= cfg_wdata[3:0];
                REG_VERSION_TEXT_LO: version_text_lo_reg <= cfg_wdata;
                REG_VERSION_TEXT_HI: version_text_hi_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser next state. The state only moves on an accepted item.
    // ------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        size_next  = size_reg;
        count_next = count_reg;
        if (s_accept) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (s_rx_byte == FRAME_HEADER) begin
                        phase_next = PH_ID;
                    end
                end
                PH_ID: begin
                    phase_next = (s_rx_byte == VERSION_ID) ? PH_SIZE : PH_IDLE;
                end
                PH_SIZE: begin
                    if (s_rx_byte != 8'd0 && s_rx_byte <= MAX_SIZE) begin
                        size_next  = s_rx_byte[6:0];
                        count_next = 7'd0;
                        phase_next = PH_PAYLOAD;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    if ({1'b0, count_reg} + 8'd1 >= {1'b0, size_reg}) begin
                        count_next = 7'd0;
                        phase_next = PH_IDLE;
                    end else begin
                        count_next = count_reg + 7'd1;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Parser outputs: a frame ends on the last accepted payload byte.
    always_comb begin
        frame_done = 1'b0;
        case (phase_reg)
            PH_PAYLOAD: begin
                frame_done = s_accept
                          && ({1'b0, count_reg} + 8'd1 >= {1'b0, size_reg});
            end
            default: frame_done = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            size_reg  <= 7'd0;
            count_reg <= 7'd0;
        end else begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Reply byte selection for the current reply index.
    // ------------------------------------------------------------------
    assign idx_wide = 4'(reply_idx_reg);
    assign text_pos = idx_wide - 4'd3;

    always_comb begin
        if (text_pos < 4'd8) begin
            text_char = version_text_lo_reg[{text_pos[2:0], 3'b000} +: 8];
        end else if (text_pos == 4'(TEXT_CHARS - 1)) begin
            text_char = version_text_hi_reg;
        end else begin
            text_char = 8'h00;
        end
    end

    always_comb begin
        case (idx_wide)
            4'd0:    reply_byte = FRAME_HEADER;
            4'd1:    reply_byte = VERSION_ID;
            4'd2:    reply_byte = TEXT_COUNT;
            default: reply_byte = (text_pos < version_length_reg) ? text_char : 8'h00;
        endcase
    end

    // ------------------------------------------------------------------
    // Reply generator and output register. A new reply item loads when the
    // output register is empty or its item is being taken.
    // ------------------------------------------------------------------
    assign out_load = reply_active_reg && (!m_valid_reg || m_ready);

    always_comb begin
        reply_active_next = reply_active_reg;
        reply_idx_next    = reply_idx_reg;
        m_valid_next      = m_valid_reg;
        m_tx_byte_next    = m_tx_byte_reg;
        m_tx_last_next    = m_tx_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (out_load) begin
            m_valid_next   = 1'b1;
            m_tx_byte_next = reply_byte;
            m_tx_last_next = (reply_idx_reg == LAST_IDX);
            if (reply_idx_reg == LAST_IDX) begin
                reply_active_next = 1'b0;
                reply_idx_next    = '0;
            end else begin
                reply_idx_next = reply_idx_reg + IDX_W'(1);
            end
        end

        // A finished frame starts a reply unless the version is too long.
        if (frame_done && version_length_reg < TEXT_LIMIT) begin
            reply_active_next = 1'b1;
            reply_idx_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_active_reg <= 1'b0;
            reply_idx_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            reply_active_reg <= reply_active_next;
            reply_idx_reg    <= reply_idx_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tx_byte_reg <= m_tx_byte_next;
        m_tx_last_reg <= m_tx_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_tx_byte = m_tx_byte_reg;
    assign m_tx_last = m_tx_last_reg;

endmodule

### tb/sv/tb_framed_request_parser_with_version_reply_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Framed request parser testbench
// Feeds received bytes into the parser core, predicts every version reply
// item from its own copy of the parser state and version registers, and
// checks each reply item against the oldest prediction.
// ============================================================================
module tb_framed_request_parser_with_version_reply_core;

    import frp_pkg::*;

    localparam int unsigned MAX_PAYLOAD      = 64;
    localparam int unsigned REPLY_TEXT_BYTES = 10;
    localparam int unsigned REPLY_LEN        = REPLY_TEXT_BYTES + 3;
    localparam int unsigned CLK_PERIOD       = 10;
    // Cycles to let pass once the last reply item is out, so that a frame
    // that produced no reply has surely finished inside the block.
    localparam int unsigned SETTLE_CYCLES    = 2 * REPLY_LEN + 4;
    // Length of the single long receiver hold-off.
    localparam int unsigned LONG_HOLD        = 300;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    // Register index outside the defined set; writes to it must be ignored.
    localparam logic [1:0]  REG_UNUSED       = 2'd3;

    // One reply item as the block should send it.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } reply_item_t;

    // Every block input starts at a known value.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_tx_byte;
    logic        m_tx_last;

    // Bytes waiting to be offered on the input channel.
    logic [7:0]  rx_pending[$];
    // Reply items predicted but not yet seen on the output channel.
    reply_item_t reply_due[$];
    int unsigned queued_total = 0;

    // Predictor copy of the parser state and the version registers.
    phase_t      parse_phase;
    logic [6:0]  pay_size;
    logic [6:0]  pay_count;
    logic [3:0]  ver_len;
    logic [63:0] ver_lo;
    logic [7:0]  ver_hi;

    // Idle percentages used by the driver and the receiver.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    // Long hold-off request: toggling hold_kick starts one hold-off.
    logic        hold_kick = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    int unsigned mismatches = 0;
    int unsigned cycle_cnt  = 0;

    framed_request_parser_with_version_reply_core #(
        .MAX_PAYLOAD      (MAX_PAYLOAD),
        .REPLY_TEXT_BYTES (REPLY_TEXT_BYTES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_tx_byte (m_tx_byte),
        .m_tx_last (m_tx_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Version character idx as the reply carries it; past the last stored
    // character the text reads as zero.
    function automatic logic [7:0] version_char(input int unsigned idx);
        if (idx < 8)
            return ver_lo[8 * idx +: 8];
        else if (idx == TEXT_CHARS - 1)
            return ver_hi;
        return 8'h00;
    endfunction

    // Mirror of a configuration write. Indexes outside the set do nothing.
    function automatic void apply_reg(input logic [1:0] idx, input logic [63:0] data);
        case (idx)
            REG_VERSION_LENGTH:  ver_len = data[3:0];
            REG_VERSION_TEXT_LO: ver_lo  = data;
            REG_VERSION_TEXT_HI: ver_hi  = data[7:0];
            default: ;
        endcase
    endfunction

    // Advances the parser copy by one accepted byte and queues any reply.
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0] rb;
        case (parse_phase)
            PH_IDLE: begin
                if (b == FRAME_HEADER)
                    parse_phase = PH_ID;
            end
            PH_ID: begin
                // A second header here also drops the frame.
                parse_phase = (b == VERSION_ID) ? PH_SIZE : PH_IDLE;
            end
            PH_SIZE: begin
                if (b != 8'h00 && b <= MAX_PAYLOAD) begin
                    pay_size    = b[6:0];
                    pay_count   = '0;
                    parse_phase = PH_PAYLOAD;
                end else begin
                    parse_phase = PH_IDLE;
                end
            end
            default: begin
                if (int'(pay_count) + 1 >= int'(pay_size)) begin
                    pay_count   = '0;
                    parse_phase = PH_IDLE;
                    // A version too long for the reply swallows the frame.
                    if (ver_len < REPLY_TEXT_BYTES) begin
                        for (int unsigned i = 0; i < REPLY_LEN; i++) begin
                            if (i == 0)
                                rb = FRAME_HEADER;
                            else if (i == 1)
                                rb = VERSION_ID;
                            else if (i == 2)
                                rb = 8'(REPLY_TEXT_BYTES);
                            else if (i - 3 < ver_len)
                                rb = version_char(i - 3);
                            else
                                rb = 8'h00;
                            reply_due.push_back('{tx_byte: rb, tx_last: (i == REPLY_LEN - 1)});
                        end
                    end
                end else begin
                    pay_count = pay_count + 7'd1;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers pending bytes, predicts each one as it is accepted.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                parse_rx_byte(s_rx_byte);
            // The payload may only change once the current item is gone.
            if (!s_valid || s_ready) begin
                if (rx_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted reply item is checked against the oldest
    // prediction, both fields.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        reply_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reply_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply item: byte %02h last %0b", m_tx_byte, m_tx_last);
            end else begin
                want = reply_due.pop_front();
                if (m_tx_byte !== want.tx_byte || m_tx_last !== want.tx_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.tx_byte, want.tx_last, m_tx_byte, m_tx_last);
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL framed_request_parser_with_version_reply_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        queued_total++;
    endtask

    // Payload content is random but leans toward framing bytes now and then,
    // since the parser must not react to them inside a payload.
    function automatic logic [7:0] payload_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return FRAME_HEADER;
        else if (roll < 14)
            return VERSION_ID;
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_frame(input int unsigned size);
        queue_byte(FRAME_HEADER);
        queue_byte(VERSION_ID);
        queue_byte(8'(size));
        repeat (size) queue_byte(payload_byte());
    endtask

    // Mostly well-formed requests, the rest noise and broken frames.
    task automatic queue_random_item();
        int unsigned roll;
        int unsigned size_roll;
        int unsigned size;
        logic [7:0]  bad_id;
        roll = $urandom_range(99);
        if (roll < 70) begin
            // Small sizes dominate; the largest size appears only rarely.
            size_roll = $urandom_range(99);
            if (size_roll < 85)
                size = $urandom_range(6, 1);
            else if (size_roll < 96)
                size = $urandom_range(20, 7);
            else
                size = MAX_PAYLOAD;
            queue_frame(size);
        end else if (roll < 78) begin
            queue_byte(8'($urandom_range(255)));
        end else if (roll < 84) begin
            queue_byte(FRAME_HEADER);
            do bad_id = 8'($urandom_range(255)); while (bad_id == VERSION_ID);
            queue_byte(bad_id);
        end else if (roll < 90) begin
            queue_byte(FRAME_HEADER);
            queue_byte(VERSION_ID);
            queue_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(255, MAX_PAYLOAD + 1)));
        end else if (roll < 95) begin
            queue_byte(FRAME_HEADER);
            queue_byte(FRAME_HEADER);
        end else begin
            // Short frame: the bytes that follow are taken as its payload.
            size = $urandom_range(8, 2);
            queue_byte(FRAME_HEADER);
            queue_byte(VERSION_ID);
            queue_byte(8'(size));
            repeat (size - 1) queue_byte(payload_byte());
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_reg(idx, data);
        @(negedge aclk);
    endtask

    // Waits until all bytes are taken, closes any open frame with filler
    // bytes, waits for the last reply item and then lets the block settle.
    task automatic drain_and_settle();
        do @(negedge aclk); while (rx_pending.size() != 0 || s_valid);
        while (parse_phase != PH_IDLE) begin
            queue_byte(8'h00);
            do @(negedge aclk); while (rx_pending.size() != 0 || s_valid);
        end
        do @(negedge aclk); while (reply_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input int unsigned tx_idle, input int unsigned rx_stall,
                             input int unsigned n_items);
        int unsigned start;
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        start        = queued_total;
        while (queued_total - start < n_items)
            queue_random_item();
        drain_and_settle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] directed_bytes[$];

        // Idle bytes, a minimal request, a wrong ID, a header in the ID slot,
        // zero and oversized sizes, and a two-byte request.
        directed_bytes = '{
            8'h00, 8'hFF, 8'h0A, 8'h55,
            8'hBB, 8'h0A, 8'h01, 8'hAA,
            8'hBB, 8'h00,
            8'hBB, 8'hBB, 8'h0A, 8'h01, 8'h00,
            8'hBB, 8'h0A, 8'h00,
            8'hBB, 8'h0A, 8'h41,
            8'hBB, 8'h0A, 8'h02, 8'hFF, 8'h00
        };

        parse_phase = PH_IDLE;
        pay_size    = '0;
        pay_count   = '0;
        ver_len     = VERSION_LENGTH_RST;
        ver_lo      = VERSION_TEXT_LO_RST;
        ver_hi      = VERSION_TEXT_HI_RST;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part against the reset configuration.
        foreach (directed_bytes[i]) queue_byte(directed_bytes[i]);
        drain_and_settle();

        // A write to an undefined index must leave the version untouched.
        write_reg(REG_UNUSED, {$urandom, $urandom});
        queue_frame(1);
        drain_and_settle();

        // Longest version text, all ones, with junk above the length field.
        write_reg(REG_VERSION_LENGTH, {$urandom, 28'($urandom), 4'd9});
        write_reg(REG_VERSION_TEXT_LO, '1);
        write_reg(REG_VERSION_TEXT_HI, 64'hFF);
        queue_frame(MAX_PAYLOAD);
        run_phase(0, 0, 20);

        // Empty version text, sender idling.
        write_reg(REG_VERSION_LENGTH, 64'd0);
        write_reg(REG_VERSION_TEXT_LO, 64'd0);
        write_reg(REG_VERSION_TEXT_HI, 64'd0);
        run_phase(66, 0, 20);

        // Random text, receiver stalling.
        write_reg(REG_VERSION_LENGTH, 64'($urandom_range(8, 1)));
        write_reg(REG_VERSION_TEXT_LO, {$urandom, $urandom});
        write_reg(REG_VERSION_TEXT_HI, 64'($urandom_range(255)));
        run_phase(0, 66, 20);

        // Version too long for the reply: frames are consumed silently.
        write_reg(REG_VERSION_LENGTH, 64'($urandom_range(15, REPLY_TEXT_BYTES)));
        run_phase(17, 17, 15);

        write_reg(REG_VERSION_LENGTH, 64'd9);
        write_reg(REG_VERSION_TEXT_LO, {$urandom, $urandom});
        write_reg(REG_VERSION_TEXT_HI, 64'($urandom_range(255)));
        run_phase(17, 17, 20);

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering requests, so the block has to stall its input.
        write_reg(REG_VERSION_LENGTH, 64'($urandom_range(REPLY_TEXT_BYTES - 1)));
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(posedge aclk);
        hold_kick <= ~hold_kick;
        @(negedge aclk);
        repeat (6) queue_frame($urandom_range(3, 1));
        drain_and_settle();

        if (mismatches == 0 && reply_due.size() == 0)
            $display("PASS framed_request_parser_with_version_reply_core");
        else
            $display("FAIL framed_request_parser_with_version_reply_core");
        $finish;
    end

endmodule

### sim.f
rtl/core/frp_pkg.sv
rtl/core/framed_request_parser_with_version_reply_core.sv
tb/sv/tb_framed_request_parser_with_version_reply_core.sv
